### rtl/spiee_pkg.sv
`default_nettype none

package spiee_pkg;

    // Event codes carried by the op field of an input item.
    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_RISE = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // Command opcodes.
    localparam logic [7:0] CMD_NONE  = 8'h00;
    localparam logic [7:0] CMD_WRITE = 8'h02;
    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] CMD_RDSR  = 8'h05;
    localparam logic [7:0] CMD_WREN  = 8'h06;

    // Value of a store byte that was never written.
    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    // Access strobes from the controller to the byte store.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

`default_nettype wire

### rtl/spi_eeprom_slave.sv
// SPI serial EEPROM target, modeled one transaction event per item: a byte exchanged
// with select low, a select rise or a time tick. In the accept cycle of an item the
// command, address and latch logic update and the byte store is read or written; in
// the next cycle the store's registered read data is available, and the result is
// loaded into the output register once that register is free or being emptied. The
// next item is accepted while an earlier result waits in the output register to be
// taken. After reset the store reads as erased (0xFF) at once through per-entry
// written flags, with no clearing pass.
`default_nettype none

module spi_eeprom_slave #(
    parameter int MEM_DEPTH = 256,
    parameter int PAGE_SIZE = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Input channel.
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [1:0]  i_op,
    input  wire  [7:0]  i_mosi_byte,
    // Output channel.
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [7:0]  o_miso_byte,
    output logic        o_busy_res,
    output logic        o_write_enabled,
    // Configuration port.
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_DEPTH - 1);

    // Byte position codes within a transaction.
    localparam logic [1:0] POS_CMD  = 2'd0;
    localparam logic [1:0] POS_ADDR = 2'd1;
    localparam logic [1:0] POS_DATA = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_RESP
    } t_state;

    // Constant tables: address byte reduced to the store and next address in a page.
    logic [AW-1:0] w_addr_red  [256];
    logic [AW-1:0] w_page_next [MEM_DEPTH];

    for (genvar g = 0; g < 256; g++) begin : g_red
        assign w_addr_red[g] = AW'(g % MEM_DEPTH);
    end

    for (genvar g = 0; g < MEM_DEPTH; g++) begin : g_page
        localparam int OFF = g % PAGE_SIZE;
        localparam int NXT = ((g - OFF) + ((OFF + 1) % PAGE_SIZE)) % MEM_DEPTH;
        assign w_page_next[g] = AW'(NXT);
    end

    t_state        r_state, n_state;
    logic [15:0]   r_ticks;
    logic          r_wel, n_wel;
    logic [15:0]   r_busy_cnt, n_busy_cnt;
    logic [7:0]    r_cmd, n_cmd;
    logic [AW-1:0] r_addr, n_addr;
    logic [1:0]    r_pos, n_pos;
    logic          r_dwr, n_dwr;
    logic [7:0]    r_miso_pend, n_miso_pend;
    logic          r_use_mem, n_use_mem;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_miso, n_miso;
    logic          r_out_busy, n_out_busy;
    logic          r_out_wel, n_out_wel;

    spiee_pkg::t_mem_ctl w_mem_ctl;
    logic [AW-1:0]       w_mem_addr;
    logic [7:0]          w_rd_data;
    logic                w_in_acc;
    logic                w_busy;
    logic [7:0]          w_status;
    logic                w_cfg_wr;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_busy     = (r_busy_cnt != 16'd0);
    assign w_status   = {6'd0, r_wel, w_busy};

    spiee_mem #(
        .MEM_DEPTH (MEM_DEPTH),
        .AW        (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_mem_ctl),
        .i_addr    (w_mem_addr),
        .i_wr_data (i_mosi_byte),
        .o_rd_data (w_rd_data)
    );

    assign w_mem_addr = r_addr;

    // Decode of one item: command, address, latch and busy updates plus store access.
    always_comb begin
        n_state     = r_state;
        n_wel       = r_wel;
        n_busy_cnt  = r_busy_cnt;
        n_cmd       = r_cmd;
        n_addr      = r_addr;
        n_pos       = r_pos;
        n_dwr       = r_dwr;
        n_miso_pend = r_miso_pend;
        n_use_mem   = r_use_mem;
        w_mem_ctl   = '0;

        if (w_in_acc) begin
            n_state     = S_RESP;
            n_miso_pend = 8'd0;
            n_use_mem   = 1'b0;
            case (i_op)
                spiee_pkg::OP_BYTE: begin
                    if (r_pos == POS_CMD) begin
                        n_cmd = spiee_pkg::CMD_NONE;
                        if (i_mosi_byte == spiee_pkg::CMD_WREN ||
                            i_mosi_byte == spiee_pkg::CMD_RDSR) begin
                            n_cmd = i_mosi_byte;
                        end else if (i_mosi_byte == spiee_pkg::CMD_READ && !w_busy) begin
                            n_cmd = i_mosi_byte;
                        end else if (i_mosi_byte == spiee_pkg::CMD_WRITE && !w_busy &&
                                     r_wel) begin
                            n_cmd = i_mosi_byte;
                        end
                        n_pos = POS_ADDR;
                    end else begin
                        if (r_cmd == spiee_pkg::CMD_WREN || r_cmd == spiee_pkg::CMD_RDSR) begin
                            n_miso_pend = w_status;
                        end else if (r_cmd == spiee_pkg::CMD_READ ||
                                     r_cmd == spiee_pkg::CMD_WRITE) begin
                            if (r_pos == POS_ADDR) begin
                                n_addr = w_addr_red[i_mosi_byte];
                            end else if (r_cmd == spiee_pkg::CMD_READ) begin
                                w_mem_ctl.rd_en = 1'b1;
                                n_use_mem       = 1'b1;
                                n_addr          = (r_addr == LAST_ADDR) ? '0 : r_addr + 1'b1;
                            end else begin
                                w_mem_ctl.wr_en = 1'b1;
                                n_dwr           = 1'b1;
                                n_addr          = w_page_next[r_addr];
                            end
                        end
                        n_pos = POS_DATA;
                    end
                end
                spiee_pkg::OP_RISE: begin
                    if (r_cmd == spiee_pkg::CMD_WREN && r_pos == POS_ADDR && !w_busy) begin
                        n_wel = 1'b1;
                    end
                    if (r_cmd == spiee_pkg::CMD_WRITE && r_dwr) begin
                        n_wel      = 1'b0;
                        n_busy_cnt = r_ticks;
                    end
                    n_cmd = spiee_pkg::CMD_NONE;
                    n_pos = POS_CMD;
                    n_dwr = 1'b0;
                end
                spiee_pkg::OP_TICK: begin
                    if (w_busy) begin
                        n_busy_cnt = r_busy_cnt - 16'd1;
                    end
                end
                default: begin
                end
            endcase
        end else if (r_state == S_RESP && (!r_out_valid || !i_out_stall)) begin
            n_state = S_IDLE;
        end
    end

    // Output register: loaded once the pending result can move out.
    always_comb begin
        n_out_valid = r_out_valid;
        n_miso      = r_miso;
        n_out_busy  = r_out_busy;
        n_out_wel   = r_out_wel;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (r_state == S_RESP && (!r_out_valid || !i_out_stall)) begin
            n_out_valid = 1'b1;
            n_miso      = r_use_mem ? w_rd_data : r_miso_pend;
            n_out_busy  = w_busy;
            n_out_wel   = r_wel;
        end
    end

    // Configuration write strobe.
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ticks     <= 16'd5000;
            r_wel       <= 1'b0;
            r_busy_cnt  <= 16'd0;
            r_cmd       <= spiee_pkg::CMD_NONE;
            r_addr      <= '0;
            r_pos       <= POS_CMD;
            r_dwr       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wel       <= n_wel;
            r_busy_cnt  <= n_busy_cnt;
            r_cmd       <= n_cmd;
            r_addr      <= n_addr;
            r_pos       <= n_pos;
            r_dwr       <= n_dwr;
            r_out_valid <= n_out_valid;
            if (w_cfg_wr && !paddr[2]) begin
                r_ticks <= pwdata[15:0];
            end
        end
        r_miso_pend <= n_miso_pend;
        r_use_mem   <= n_use_mem;
        r_miso      <= n_miso;
        r_out_busy  <= n_out_busy;
        r_out_wel   <= n_out_wel;
    end

    assign o_out_valid     = r_out_valid;
    assign o_miso_byte     = r_miso;
    assign o_busy_res      = r_out_busy;
    assign o_write_enabled = r_out_wel;
    assign pready          = 1'b1;
    assign prdata          = paddr[2] ? 32'd0 : {16'd0, r_ticks};

    // The byte position never takes its unused code.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos != 2'd3)
        else $error("byte position out of range");

    // The store is never read and written in the same cycle.
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mem_ctl.rd_en && w_mem_ctl.wr_en))
        else $error("store read and write collide");

    // A pending result with a free output slot is presented next cycle.
    a_resp_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && !r_out_valid) |=> (r_out_valid && r_state == S_IDLE))
        else $error("pending result not delivered");

    // A store read is followed by a result taken from the store.
    a_read_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_ctl.rd_en |=> (r_use_mem && r_state == S_RESP))
        else $error("store read data not used");

endmodule

`default_nettype wire

### rtl/spiee_mem.sv
`default_nettype none

module spiee_mem #(
    parameter int MEM_DEPTH = 256,
    parameter int AW        = 8
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire spiee_pkg::t_mem_ctl i_ctl,
    input  wire  [AW-1:0]           i_addr,
    input  wire  [7:0]              i_wr_data,
    output logic [7:0]              o_rd_data
);

    logic [7:0] r_mem [MEM_DEPTH];
    logic       r_valid [MEM_DEPTH];
    logic [7:0] r_rd_data;

    // Byte array: one write or one read per cycle, read data registered.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_valid[i_addr] ? r_mem[i_addr] : spiee_pkg::ERASED_BYTE;
        end
    end

    // Written flags make every entry read as erased after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MEM_DEPTH; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (i_ctl.wr_en) begin
            r_valid[i_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int         MEM_DEPTH   = 256;
    localparam int         PAGE_SIZE   = 16;
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [2:0] REG_WR_TIME = 3'd0;
    localparam logic [15:0] RESET_WR_TIME = 16'd5000;
    localparam int         STUCK_LIMIT = 4000;
    localparam int         PRINT_CAP   = 100;
    localparam int         SETTLE_CYCLES = 6;

    // One reply item as the block returns it.
    typedef struct packed {
        logic [7:0] miso;
        logic       busy;
        logic       wel;
    } t_spi_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_op = '0;
    logic [7:0]  i_mosi_byte = '0;
    logic        i_out_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire         o_in_stall;
    wire         o_out_valid;
    wire  [7:0]  o_miso_byte;
    wire         o_busy_res;
    wire         o_write_enabled;
    wire  [31:0] prdata;
    wire         pready;

    spi_eeprom_slave #(
        .MEM_DEPTH(MEM_DEPTH),
        .PAGE_SIZE(PAGE_SIZE)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_op(i_op),
        .i_mosi_byte(i_mosi_byte),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_miso_byte(o_miso_byte),
        .o_busy_res(o_busy_res),
        .o_write_enabled(o_write_enabled),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // Shadow copy of the EEPROM state.
    logic [7:0]  mem_img [MEM_DEPTH];
    logic        wel = 1'b0;
    logic [15:0] busy_left = '0;
    logic [7:0]  cur_cmd = spiee_pkg::CMD_NONE;
    logic [7:0]  addr_ptr = '0;
    logic [1:0]  byte_pos = '0;
    logic        wrote_data = 1'b0;
    logic [15:0] write_time = RESET_WR_TIME;

    t_spi_reply  expected_replies[$];
    t_spi_reply  want_reply;
    int          mismatches = 0;
    int          items_sent = 0;
    int          replies_checked = 0;
    int          settings_used = 1;
    int          stuck_cycles = 0;
    int          out_hold = 0;
    bit          no_gaps = 1'b0;
    logic [7:0]  last_write_base = '0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Advance the shadow state by one event and return the reply it produces.
    function automatic t_spi_reply predict_spi_event(input logic [1:0] op, input logic [7:0] b);
        t_spi_reply r;
        logic       busy;
        r = '0;
        busy = (busy_left != 16'd0);
        case (op)
            spiee_pkg::OP_BYTE: begin
                if (byte_pos == 2'd0) begin
                    // Command byte: read and write are refused while busy.
                    if (b == spiee_pkg::CMD_WREN || b == spiee_pkg::CMD_RDSR)
                        cur_cmd = b;
                    else if (b == spiee_pkg::CMD_READ && !busy)
                        cur_cmd = b;
                    else if (b == spiee_pkg::CMD_WRITE && !busy && wel)
                        cur_cmd = b;
                    else
                        cur_cmd = spiee_pkg::CMD_NONE;
                    byte_pos = 2'd1;
                end else begin
                    if (cur_cmd == spiee_pkg::CMD_WREN || cur_cmd == spiee_pkg::CMD_RDSR) begin
                        r.miso = {6'b0, wel, busy};
                    end else if (cur_cmd == spiee_pkg::CMD_READ ||
                                 cur_cmd == spiee_pkg::CMD_WRITE) begin
                        if (byte_pos == 2'd1) begin
                            addr_ptr = b;
                        end else if (cur_cmd == spiee_pkg::CMD_READ) begin
                            r.miso = mem_img[addr_ptr];
                            addr_ptr = addr_ptr + 8'd1;
                        end else begin
                            // Data lands at once; the address wraps inside its 16-byte page.
                            mem_img[addr_ptr] = b;
                            wrote_data = 1'b1;
                            addr_ptr = {addr_ptr[7:4], addr_ptr[3:0] + 4'd1};
                        end
                    end
                    byte_pos = 2'd2;
                end
            end
            spiee_pkg::OP_RISE: begin
                if (cur_cmd == spiee_pkg::CMD_WREN && byte_pos == 2'd1 && !busy)
                    wel = 1'b1;
                if (cur_cmd == spiee_pkg::CMD_WRITE && wrote_data) begin
                    wel = 1'b0;
                    busy_left = write_time;
                end
                cur_cmd = spiee_pkg::CMD_NONE;
                byte_pos = 2'd0;
                wrote_data = 1'b0;
            end
            spiee_pkg::OP_TICK: begin
                if (busy)
                    busy_left = busy_left - 16'd1;
            end
            default: ;
        endcase
        r.busy = (busy_left != 16'd0);
        r.wel = wel;
        return r;
    endfunction

    function automatic logic [7:0] rand_byte();
        logic [31:0] r;
        r = $urandom;
        return r[7:0];
    endfunction

    // Idle length: mostly short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 8);
        return $urandom_range(12, 40);
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] MISMATCH %s", $time, what);
    endtask

    // Offer one item, wait for it to be taken, and record the reply it must produce.
    task automatic send_event(input logic [1:0] op, input logic [7:0] b);
        int gap;
        gap = 0;
        if (!no_gaps && $urandom_range(0, 2) == 0)
            gap = idle_len();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_mosi_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        expected_replies.push_back(predict_spi_event(op, b));
        items_sent++;
    endtask

    // Stop offering items and let every outstanding reply come back.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register access: setup cycle, then access cycle until pready.
    task automatic apb_access(input logic wr, input logic [15:0] value, output logic [31:0] rd);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= REG_WR_TIME;
        pwdata <= {16'h0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // Change the write cycle length while idle, then read it back.
    task automatic set_write_time(input logic [15:0] value);
        logic [31:0] rd;
        wait_idle();
        apb_access(1'b1, value, rd);
        write_time = value;
        settings_used++;
        apb_access(1'b0, 16'h0, rd);
        if (rd !== {16'h0, value})
            report_mismatch($sformatf("write time readback %08h, want %08h", rd, value));
    endtask

    // A write transaction with random content, then polling until the cycle ends.
    task automatic write_and_poll();
        int len;
        int pick;
        last_write_base = rand_byte();
        if ($urandom_range(0, 9) != 0) begin
            send_event(spiee_pkg::OP_BYTE, spiee_pkg::CMD_WREN);
            send_event(spiee_pkg::OP_RISE, rand_byte());
        end
        send_event(spiee_pkg::OP_BYTE, spiee_pkg::CMD_WRITE);
        send_event(spiee_pkg::OP_BYTE, last_write_base);
        pick = $urandom_range(0, 99);
        if (pick < 3)
            len = 0;
        else if (pick < 80)
            len = $urandom_range(1, 8);
        else if (pick < 95)
            len = $urandom_range(9, 20);
        else
            len = $urandom_range(17, 40);
        repeat (len) send_event(spiee_pkg::OP_BYTE, rand_byte());
        send_event(spiee_pkg::OP_RISE, rand_byte());
        while (busy_left != 16'd0) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                send_event(spiee_pkg::OP_TICK, rand_byte());
            end else if (pick < 9) begin
                send_event(spiee_pkg::OP_BYTE, spiee_pkg::CMD_RDSR);
                send_event(spiee_pkg::OP_BYTE, rand_byte());
                send_event(spiee_pkg::OP_RISE, rand_byte());
            end else begin
                // Commands that must be refused during the write cycle.
                send_event(spiee_pkg::OP_BYTE,
                           (pick[0]) ? spiee_pkg::CMD_READ : spiee_pkg::CMD_WRITE);
                send_event(spiee_pkg::OP_BYTE, rand_byte());
                send_event(spiee_pkg::OP_BYTE, rand_byte());
                send_event(spiee_pkg::OP_RISE, rand_byte());
            end
        end
    endtask

    // One random transaction: mostly well formed, some noise and broken sequences.
    task automatic random_transaction();
        int         kind;
        int         len;
        logic [7:0] base;
        logic [7:0] r8;
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            send_event(spiee_pkg::OP_BYTE, spiee_pkg::CMD_RDSR);
            repeat ($urandom_range(0, 4)) send_event(spiee_pkg::OP_BYTE, rand_byte());
            send_event(spiee_pkg::OP_RISE, rand_byte());
        end else if (kind < 22) begin
            send_event(spiee_pkg::OP_BYTE, spiee_pkg::CMD_WREN);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) send_event(spiee_pkg::OP_BYTE, rand_byte());
            send_event(spiee_pkg::OP_RISE, rand_byte());
        end else if (kind < 55) begin
            write_and_poll();
        end else if (kind < 80) begin
            base = ($urandom_range(0, 1) == 0) ? last_write_base : rand_byte();
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 12);
            send_event(spiee_pkg::OP_BYTE, spiee_pkg::CMD_READ);
            send_event(spiee_pkg::OP_BYTE, base);
            repeat (len) send_event(spiee_pkg::OP_BYTE, rand_byte());
            send_event(spiee_pkg::OP_RISE, rand_byte());
        end else if (kind < 88) begin
            repeat ($urandom_range(1, 5)) send_event(spiee_pkg::OP_TICK, rand_byte());
        end else begin
            repeat ($urandom_range(1, 6)) begin
                r8 = rand_byte();
                send_event(r8[1:0], rand_byte());
            end
            if ($urandom_range(0, 1) == 0)
                send_event(spiee_pkg::OP_RISE, rand_byte());
        end
    endtask

    // Reset value of the register, then a short write cycle for the directed part.
    task automatic test_register_access();
        logic [31:0] rd;
        apb_access(1'b0, 16'h0, rd);
        if (rd !== {16'h0, RESET_WR_TIME})
            report_mismatch($sformatf("write time after reset %08h", rd));
        set_write_time(16'd2);
    endtask

    // Each command and each corner of the protocol once.
    task automatic test_directed_commands();
        // Unused op code and an idle tick change nothing.
        send_event(OP_UNUSED, 8'hFF);
        send_event(spiee_pkg::OP_TICK, 8'h00);
        // Write enable with trailing bytes acts as status read and leaves the latch clear.
        send_event(spiee_pkg::OP_BYTE, spiee_pkg::CMD_WREN);
        send_event(spiee_pkg::OP_BYTE, 8'hAA);
        send_event(spiee_pkg::OP_RISE, 8'h00);
        // Plain write enable sets the latch.
        send_event(spiee_pkg::OP_BYTE, spiee_pkg::CMD_WREN);
        send_event(spiee_pkg::OP_RISE, 8'hFF);
        // Write with no data byte leaves everything as it was.
        send_event(spiee_pkg::OP_BYTE, spiee_pkg::CMD_WRITE);
        send_event(spiee_pkg::OP_BYTE, 8'h10);
        send_event(spiee_pkg::OP_RISE, 8'h00);
        // Write at the top of a page wraps to the page start, then starts the cycle.
        send_event(spiee_pkg::OP_BYTE, spiee_pkg::CMD_WRITE);
        send_event(spiee_pkg::OP_BYTE, 8'hFF);
        send_event(spiee_pkg::OP_BYTE, 8'h00);
        send_event(spiee_pkg::OP_BYTE, 8'h5A);
        send_event(spiee_pkg::OP_RISE, 8'h00);
        // Read is refused while busy; status shows the busy bit.
        send_event(spiee_pkg::OP_BYTE, spiee_pkg::CMD_READ);
        send_event(spiee_pkg::OP_RISE, 8'h00);
        send_event(spiee_pkg::OP_BYTE, spiee_pkg::CMD_RDSR);
        send_event(spiee_pkg::OP_BYTE, 8'hFF);
        send_event(spiee_pkg::OP_RISE, 8'h00);
        send_event(spiee_pkg::OP_TICK, 8'hFF);
        send_event(spiee_pkg::OP_TICK, 8'h00);
        // Read across the top of memory back to address zero.
        send_event(spiee_pkg::OP_BYTE, spiee_pkg::CMD_READ);
        send_event(spiee_pkg::OP_BYTE, 8'hFF);
        send_event(spiee_pkg::OP_BYTE, 8'h00);
        send_event(spiee_pkg::OP_BYTE, 8'hFF);
        send_event(spiee_pkg::OP_RISE, 8'h00);
    endtask

    // A zero write cycle ends the write with no busy time at all.
    task automatic test_zero_write_cycle();
        set_write_time(16'd0);
        send_event(spiee_pkg::OP_BYTE, spiee_pkg::CMD_WREN);
        send_event(spiee_pkg::OP_RISE, 8'h00);
        send_event(spiee_pkg::OP_BYTE, spiee_pkg::CMD_WRITE);
        send_event(spiee_pkg::OP_BYTE, 8'h37);
        send_event(spiee_pkg::OP_BYTE, 8'hC3);
        send_event(spiee_pkg::OP_RISE, 8'h00);
        send_event(spiee_pkg::OP_BYTE, spiee_pkg::CMD_RDSR);
        send_event(spiee_pkg::OP_BYTE, 8'h00);
        send_event(spiee_pkg::OP_RISE, 8'h00);
        send_event(spiee_pkg::OP_BYTE, spiee_pkg::CMD_READ);
        send_event(spiee_pkg::OP_BYTE, 8'h37);
        send_event(spiee_pkg::OP_BYTE, 8'h00);
        send_event(spiee_pkg::OP_RISE, 8'h00);
    endtask

    // Random traffic under one write cycle setting.
    task automatic test_random_traffic(input logic [15:0] ticks, input bit gaps_on,
                                       input int count);
        int start;
        set_write_time(ticks);
        no_gaps = !gaps_on;
        start = items_sent;
        while (items_sent - start < count)
            random_transaction();
        no_gaps = 1'b0;
    endtask

    // Longest write cycle: the block stays busy for the rest of the run.
    task automatic test_long_write_cycle();
        set_write_time(16'hFFFF);
        send_event(spiee_pkg::OP_BYTE, spiee_pkg::CMD_WREN);
        send_event(spiee_pkg::OP_RISE, 8'h00);
        send_event(spiee_pkg::OP_BYTE, spiee_pkg::CMD_WRITE);
        send_event(spiee_pkg::OP_BYTE, 8'h80);
        send_event(spiee_pkg::OP_BYTE, 8'hA5);
        send_event(spiee_pkg::OP_BYTE, 8'h5A);
        send_event(spiee_pkg::OP_RISE, 8'h00);
        repeat (4) begin
            send_event(spiee_pkg::OP_BYTE, spiee_pkg::CMD_WREN);
            send_event(spiee_pkg::OP_RISE, rand_byte());
            send_event(spiee_pkg::OP_BYTE, spiee_pkg::CMD_WRITE);
            send_event(spiee_pkg::OP_BYTE, rand_byte());
            send_event(spiee_pkg::OP_BYTE, rand_byte());
            send_event(spiee_pkg::OP_RISE, rand_byte());
            send_event(spiee_pkg::OP_TICK, rand_byte());
            send_event(spiee_pkg::OP_BYTE, spiee_pkg::CMD_RDSR);
            send_event(spiee_pkg::OP_BYTE, rand_byte());
            send_event(spiee_pkg::OP_RISE, rand_byte());
        end
    endtask

    // Random stall on the reply side.
    always @(posedge i_clk) begin
        if (out_hold != 0) begin
            i_out_stall <= 1'b1;
            out_hold <= out_hold - 1;
        end else begin
            i_out_stall <= 1'b0;
            if (!no_gaps && $urandom_range(0, 3) == 0)
                out_hold <= idle_len();
        end
    end

    // Compare each reply taken with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_replies.size() == 0) begin
                report_mismatch($sformatf("reply with none pending: miso %02h busy %0b wel %0b",
                                          o_miso_byte, o_busy_res, o_write_enabled));
            end else begin
                want_reply = expected_replies.pop_front();
                if (o_miso_byte !== want_reply.miso || o_busy_res !== want_reply.busy ||
                    o_write_enabled !== want_reply.wel)
                    report_mismatch($sformatf(
                        "reply %0d: miso %02h/%02h busy %0b/%0b wel %0b/%0b (got/want)",
                        replies_checked, o_miso_byte, want_reply.miso, o_busy_res,
                        want_reply.busy, o_write_enabled, want_reply.wel));
                replies_checked++;
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        foreach (mem_img[i])
            mem_img[i] = spiee_pkg::ERASED_BYTE;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_access();
        test_directed_commands();
        test_random_traffic(16'd1, 1'b1, 300);
        test_random_traffic(16'd9, 1'b1, 300);
        test_zero_write_cycle();
        test_random_traffic(16'($urandom_range(2, 40)), 1'b0, 300);
        test_random_traffic(16'd30, 1'b1, 300);
        test_long_write_cycle();
        wait_idle();

        $display("Covered %0d bus events and %0d replies over %0d write cycle settings.",
                 items_sent, replies_checked, settings_used);
        $display("Mismatches found: %0d.", mismatches);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
